[hw/rtl/kf2_pkg.sv]
// Shared types and constants for the two-state Kalman filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kf2_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  localparam int REG_TIME_STEP = 0;
  localparam int REG_PROC_POS  = 1;
  localparam int REG_PROC_VEL  = 2;
  localparam int REG_MEAS      = 3;

  localparam int CFG_WIDTH = 31;
  localparam int IDX_WIDTH = 2;

  localparam logic [16:0] RST_TIME_STEP = 17'd655;
  localparam logic [30:0] RST_PROC_POS  = 31'd65536;
  localparam logic [30:0] RST_PROC_VEL  = 31'd655360;
  localparam logic [30:0] RST_MEAS      = 31'd6553600;

endpackage
`default_nettype wire

[hw/rtl/kf2_alu.sv]
// Shared saturating arithmetic unit: add, subtract, rounded multiply, divide.
// Multiply and divide iterate one bit per cycle. Depends on kf2_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kf2_alu import kf2_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire alu_op_t                      op,
  input  wire logic signed [WORD_WIDTH-1:0] a,
  input  wire logic signed [WORD_WIDTH-1:0] b,
  output logic                              done,
  output logic signed [WORD_WIDTH-1:0]      result,
  output logic                              clip
);

  localparam int W   = WORD_WIDTH;
  localparam int PW  = 2 * W;
  localparam int DN  = W + FRAC_BITS;
  localparam int CW  = $clog2(DN + 1);
  localparam logic [W:0] TOP  = {2'b01, {(W-1){1'b0}}};
  localparam logic [W:0] WMAX = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t state;
  alu_op_t op_r;
  logic neg;
  logic [W-1:0] ma, mb;
  logic [PW-1:0] prod;
  logic [DN-1:0] numr;
  logic [W:0] rem;
  logic [DN-1:0] quo;
  logic [CW-1:0] cnt;

  logic [W-1:0] mag_a, mag_b;
  logic signed [W:0] sum;
  logic [W:0] rem_sh;
  logic [PW:0] rnd;
  logic [W:0] mag_res;
  logic ovf;

  assign mag_a = a[W-1] ? W'(-a) : W'(a);
  assign mag_b = b[W-1] ? W'(-b) : W'(b);
  assign rem_sh = {rem[W-1:0], numr[DN-1]};
  assign sum = (op == OP_SUB) ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});

  always_comb begin
    rnd = {1'b0, prod} + (PW+1)'({1'b1, {(FRAC_BITS-1){1'b0}}});
    mag_res = '0;
    ovf = 1'b0;
    if (op_r == OP_MUL) begin
      mag_res = rnd[FRAC_BITS +: W+1];
      ovf = |rnd[PW:FRAC_BITS+W+1];
    end else begin
      mag_res = quo[W:0];
      ovf = |quo[DN-1:W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r <= op;
            neg <= a[W-1] ^ b[W-1];
            ma <= mag_a;
            mb <= mag_b;
            prod <= '0;
            rem <= '0;
            quo <= '0;
            numr <= {mag_a, {FRAC_BITS{1'b0}}};
            cnt <= '0;
            if (op == OP_ADD || op == OP_SUB) begin
              clip <= sum[W] != sum[W-1];
              result <= (sum[W] != sum[W-1]) ? (sum[W] ? SMIN : SMAX) : sum[W-1:0];
              done <= 1'b1;
            end else if (op == OP_MUL) begin
              state <= S_MUL;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          if (mb[0]) prod <= prod + (PW'(ma) << cnt);
          mb <= mb >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) state <= S_FIN;
        end
        S_DIV: begin
          numr <= numr << 1;
          if (rem_sh >= {1'b0, mb}) begin
            rem <= rem_sh - {1'b0, mb};
            quo <= {quo[DN-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DN-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DN - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (ovf || mag_res > (neg ? TOP : WMAX)) begin
            clip <= 1'b1;
            result <= neg ? SMIN : SMAX;
          end else begin
            clip <= 1'b0;
            result <= neg ? W'(-mag_res) : mag_res[W-1:0];
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/kalman_filter_two_state_unit.sv]
// Top level of the two-state Kalman filter: sequencer, state, config, output.
// Depends on kf2_pkg and kf2_alu.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel (in_valid/in_ready) carries measured_position and control_input.
//   Output channel (out_valid/out_ready) carries both estimates and saturated.
//   Config writes (cfg_write, cfg_index, cfg_data) land at once; write only when idle.
// Sequencing:
//   One step runs 30 operations in sequence on the single shared ALU, each one
//   issued and then awaited until the ALU reports done. The two divides are
//   skipped, leaving 28 operations, when the gain denominator is zero or
//   negative. The ALU's bit-serial multiply and divide set most of the step time.
//   in_ready is high only while idle, so no new transaction is taken while a
//   step is running.
// Reset:
//   Registers return to their defaults; estimates and covariance clear to zero.
// Stall:
//   A result holds in the output register until out_ready; the next input is
//   accepted meanwhile and runs until its own result is ready, then holds.
module kalman_filter_two_state_unit import kf2_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [31:0]   measured_position,
  input  wire logic signed [31:0]   control_input,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        position_estimate,
  output logic signed [31:0]        velocity_estimate,
  output logic                      saturated,
  input  wire logic                 cfg_write,
  input  wire logic [IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int W = WORD_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [63:0] SMAX64 = 64'(SMAX);
  localparam logic signed [63:0] SMIN64 = 64'(SMIN);

  typedef enum logic [2:0] {
    R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7
  } rsel_t;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_t;

  logic [16:0] time_step;
  logic [30:0] proc_pos, proc_vel, meas;

  logic signed [W-1:0] xp, xv, p00, p01, p10, p11;
  logic signed [W-1:0] dt, qp, qv, rr, z, u;
  logic signed [W-1:0] t [8];
  logic signed [W-1:0] k0, k1;
  logic flag;
  state_t state;
  logic [4:0] pc;
  logic have_out;

  logic alu_start, alu_done, alu_clip;
  alu_op_t alu_op;
  logic signed [W-1:0] alu_a, alu_b, alu_res;

  function automatic logic signed [W-1:0] clamp_w(input logic signed [63:0] v,
                                                 output logic c);
    c = 1'b0;
    if (v > SMAX64) begin
      c = 1'b1;
      return SMAX;
    end else if (v < SMIN64) begin
      c = 1'b1;
      return SMIN;
    end
    return W'(v);
  endfunction

  kf2_alu #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .op(alu_op), .a(alu_a), .b(alu_b),
    .done(alu_done), .result(alu_res), .clip(alu_clip)
  );

  // Program: t slots hold intermediates. Step index pc selects op, operands, dest.
  // 0 t0=dt*xv  1 xp0=xp+t0 ->t1  2 t0=dt*u  3 xp1=xv+t0 ->t2
  // 4 t0=dt*p10 5 t3=p00+t0  6 t0=dt*p11 7 t4=p01+t0 (pp01)
  // 8 t0=dt*t4  9 t3=t3+t0  10 t5=t3+qp (pp00) 11 t6=p10+dt*p11: t0=dt*p11
  // 12 t6=p10+t0 (pp10) 13 t7=p11+qv (pp11) 14 t0=r+t5 (den)
  // 15 k0=t5/t0 16 k1=t6/t0 17 t3=z-t1 (e) 18 t0=k0*t3 19 xp=t1+t0
  // 20 t0=k1*t3 21 xv=t2+t0 22 t0=k0*t5 23 p00=t5-t0 24 t0=k0*t4
  // 25 p01=t4-t0 26 t0=k1*t5 27 p10=t6-t0 28 t0=k1*t4 29 p11=t7-t0
  localparam logic [4:0] LAST = 5'd29;

  always_comb begin
    alu_op = OP_MUL;
    alu_a = dt;
    alu_b = xv;
    case (pc)
      5'd0: begin alu_op = OP_MUL; alu_a = dt; alu_b = xv; end
      5'd1: begin alu_op = OP_ADD; alu_a = xp; alu_b = t[0]; end
      5'd2: begin alu_op = OP_MUL; alu_a = dt; alu_b = u; end
      5'd3: begin alu_op = OP_ADD; alu_a = xv; alu_b = t[0]; end
      5'd4: begin alu_op = OP_MUL; alu_a = dt; alu_b = p10; end
      5'd5: begin alu_op = OP_ADD; alu_a = p00; alu_b = t[0]; end
      5'd6: begin alu_op = OP_MUL; alu_a = dt; alu_b = p11; end
      5'd7: begin alu_op = OP_ADD; alu_a = p01; alu_b = t[0]; end
      5'd8: begin alu_op = OP_MUL; alu_a = dt; alu_b = t[4]; end
      5'd9: begin alu_op = OP_ADD; alu_a = t[3]; alu_b = t[0]; end
      5'd10: begin alu_op = OP_ADD; alu_a = t[3]; alu_b = qp; end
      5'd11: begin alu_op = OP_MUL; alu_a = dt; alu_b = p11; end
      5'd12: begin alu_op = OP_ADD; alu_a = p10; alu_b = t[0]; end
      5'd13: begin alu_op = OP_ADD; alu_a = p11; alu_b = qv; end
      5'd14: begin alu_op = OP_ADD; alu_a = rr; alu_b = t[5]; end
      5'd15: begin alu_op = OP_DIV; alu_a = t[5]; alu_b = t[0]; end
      5'd16: begin alu_op = OP_DIV; alu_a = t[6]; alu_b = t[0]; end
      5'd17: begin alu_op = OP_SUB; alu_a = z; alu_b = t[1]; end
      5'd18: begin alu_op = OP_MUL; alu_a = k0; alu_b = t[3]; end
      5'd19: begin alu_op = OP_ADD; alu_a = t[1]; alu_b = t[0]; end
      5'd20: begin alu_op = OP_MUL; alu_a = k1; alu_b = t[3]; end
      5'd21: begin alu_op = OP_ADD; alu_a = t[2]; alu_b = t[0]; end
      5'd22: begin alu_op = OP_MUL; alu_a = k0; alu_b = t[5]; end
      5'd23: begin alu_op = OP_SUB; alu_a = t[5]; alu_b = t[0]; end
      5'd24: begin alu_op = OP_MUL; alu_a = k0; alu_b = t[4]; end
      5'd25: begin alu_op = OP_SUB; alu_a = t[4]; alu_b = t[0]; end
      5'd26: begin alu_op = OP_MUL; alu_a = k1; alu_b = t[5]; end
      5'd27: begin alu_op = OP_SUB; alu_a = t[6]; alu_b = t[0]; end
      5'd28: begin alu_op = OP_MUL; alu_a = k1; alu_b = t[4]; end
      5'd29: begin alu_op = OP_SUB; alu_a = t[7]; alu_b = t[0]; end
      default: begin alu_op = OP_ADD; alu_a = xp; alu_b = t[0]; end
    endcase
  end

  assign alu_start = (state == S_ISSUE);
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    logic c0, c1, c2, c3, c4, c5, c6;
    logic signed [W-1:0] o0, o1;
    if (rst) begin
      time_step <= RST_TIME_STEP;
      proc_pos <= RST_PROC_POS;
      proc_vel <= RST_PROC_VEL;
      meas <= RST_MEAS;
      xp <= '0; xv <= '0; p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      state <= S_IDLE;
      pc <= '0;
      flag <= 1'b0;
      out_valid <= 1'b0;
      have_out <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          2'(REG_TIME_STEP): time_step <= cfg_data[16:0];
          2'(REG_PROC_POS):  proc_pos <= cfg_data;
          2'(REG_PROC_VEL):  proc_vel <= cfg_data;
          2'(REG_MEAS):      meas <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
        have_out <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dt <= clamp_w(64'(time_step), c0);
            qp <= clamp_w(64'(proc_pos), c1);
            qv <= clamp_w(64'(proc_vel), c2);
            rr <= clamp_w(64'(meas), c3);
            z <= clamp_w(64'(measured_position), c4);
            u <= clamp_w(64'(control_input), c5);
            flag <= c0 | c1 | c2 | c3 | c4 | c5;
            k0 <= '0;
            k1 <= '0;
            pc <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (alu_done) begin
            flag <= flag | alu_clip;
            state <= S_ISSUE;
            case (pc)
              5'd1: t[1] <= alu_res;
              5'd3: t[2] <= alu_res;
              5'd5, 5'd9: t[3] <= alu_res;
              5'd7: t[4] <= alu_res;
              5'd10: t[5] <= alu_res;
              5'd12: t[6] <= alu_res;
              5'd13: t[7] <= alu_res;
              5'd15: k0 <= alu_res;
              5'd16: k1 <= alu_res;
              5'd17: t[3] <= alu_res;
              5'd19: xp <= alu_res;
              5'd21: xv <= alu_res;
              5'd23: p00 <= alu_res;
              5'd25: p01 <= alu_res;
              5'd27: p10 <= alu_res;
              5'd29: p11 <= alu_res;
              default: t[0] <= alu_res;
            endcase
            if (pc == 5'd14) begin
              if (alu_res[W-1] || alu_res == '0) pc <= 5'd17;
              else pc <= 5'd15;
            end else if (pc == LAST) begin
              state <= S_DONE;
            end else begin
              pc <= pc + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!have_out) begin
            o0 = clamp_w(64'(xp) > 64'sh7FFFFFFF ? 64'sh7FFFFFFF :
                         (64'(xp) < -64'sh80000000 ? -64'sh80000000 : 64'(xp)), c6);
            o1 = clamp_w(64'(xv) > 64'sh7FFFFFFF ? 64'sh7FFFFFFF :
                         (64'(xv) < -64'sh80000000 ? -64'sh80000000 : 64'(xv)), c6);
            position_estimate <= 32'(o0);
            velocity_estimate <= 32'(o1);
            saturated <= flag
                       | (64'(xp) > 64'sh7FFFFFFF) | (64'(xp) < -64'sh80000000)
                       | (64'(xv) > 64'sh7FFFFFFF) | (64'(xv) < -64'sh80000000);
            out_valid <= 1'b1;
            have_out <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the two-state Kalman filter unit: directed and random steps,
// register settings, idle and backpressure phases, checked against an in-bench predictor.
// Depends on kf2_pkg and kalman_filter_two_state_unit.
`timescale 1ns / 1ps
module testbench;
  import kf2_pkg::*;

  localparam int FRAC = 16;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct {
    longint pos;
    longint vel;
    bit     sat;
  } estimate_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [31:0]    measured_position;
  logic signed [31:0]    control_input;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [31:0]    position_estimate;
  logic signed [31:0]    velocity_estimate;
  logic                  saturated;
  logic                  cfg_write;
  logic [IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_WIDTH-1:0]  cfg_data;

  kalman_filter_two_state_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .measured_position(measured_position), .control_input(control_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .position_estimate(position_estimate), .velocity_estimate(velocity_estimate),
    .saturated(saturated),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // filter model state
  longint    dt_q, qpos_q, qvel_q, rmeas_q;
  longint    x_pos, x_vel;
  longint    cov[4];
  bit        clipped;
  estimate_t pending_estimates[$];

  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_req;
  int   hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("testbench: errors");
    $finish;
  end

  function automatic longint sat_word(longint v);
    if (v > WMAX) begin
      clipped = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      clipped = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_result(longint unsigned m, bit neg);
    if (neg) begin
      if (m > 64'd2147483648) begin
        clipped = 1'b1;
        return WMIN;
      end
      return -longint'(m);
    end
    if (m > 64'd2147483647) begin
      clipped = 1'b1;
      return WMAX;
    end
    return longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned m;
    m = (magnitude(a) * magnitude(b) + (64'd1 << (FRAC - 1))) >> FRAC;
    return signed_result(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint unsigned m;
    m = (magnitude(n) << FRAC) / magnitude(d);
    return signed_result(m, (n < 0) != (d < 0));
  endfunction

  function automatic estimate_t filter_step(longint z, longint u);
    estimate_t e;
    longint xp0, xp1, t0, t1, pp00, pp01, pp10, pp11, den, k0, k1, inn;
    clipped = 1'b0;
    k0 = 0;
    k1 = 0;
    xp0 = sat_word(x_pos + fx_mul(dt_q, x_vel));
    xp1 = sat_word(x_vel + fx_mul(dt_q, u));
    t0 = sat_word(cov[0] + fx_mul(dt_q, cov[2]));
    t1 = sat_word(cov[1] + fx_mul(dt_q, cov[3]));
    pp00 = sat_word(sat_word(t0 + fx_mul(dt_q, t1)) + qpos_q);
    pp01 = t1;
    pp10 = sat_word(cov[2] + fx_mul(dt_q, cov[3]));
    pp11 = sat_word(cov[3] + qvel_q);
    den = sat_word(rmeas_q + pp00);
    if (den > 0) begin
      k0 = fx_div(pp00, den);
      k1 = fx_div(pp10, den);
    end
    inn = sat_word(z - xp0);
    x_pos = sat_word(xp0 + fx_mul(k0, inn));
    x_vel = sat_word(xp1 + fx_mul(k1, inn));
    cov[0] = sat_word(pp00 - fx_mul(k0, pp00));
    cov[1] = sat_word(pp01 - fx_mul(k0, pp01));
    cov[2] = sat_word(pp10 - fx_mul(k1, pp00));
    cov[3] = sat_word(pp11 - fx_mul(k1, pp01));
    e.pos = x_pos;
    e.vel = x_vel;
    e.sat = clipped;
    return e;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic send_measurement(logic signed [31:0] z, logic signed [31:0] u);
    int n;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_position <= z;
    control_input <= u;
    do @(posedge clk); while (!in_ready);
    pending_estimates.push_back(filter_step(longint'(z), longint'(u)));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_estimates.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(int idx, logic [CFG_WIDTH-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= IDX_WIDTH'(idx);
    cfg_data <= value;
    case (idx)
      REG_TIME_STEP: dt_q = longint'(value & 31'h1FFFF);
      REG_PROC_POS:  qpos_q = longint'(value);
      REG_PROC_VEL:  qvel_q = longint'(value);
      REG_MEAS:      rmeas_q = longint'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(logic [CFG_WIDTH-1:0] dt, logic [CFG_WIDTH-1:0] qp,
                           logic [CFG_WIDTH-1:0] qv, logic [CFG_WIDTH-1:0] r);
    write_register(REG_TIME_STEP, dt);
    write_register(REG_PROC_POS, qp);
    write_register(REG_PROC_VEL, qv);
    write_register(REG_MEAS, r);
  endtask

  function automatic logic signed [31:0] random_value();
    if ($urandom_range(1) == 0) return $urandom;
    return $signed($urandom_range(0, 26214400)) - 32'sd13107200;
  endfunction

  task automatic test_default_settings;
    send_measurement(32'sd0, 32'sd0);
    send_measurement(32'sd65536, 32'sd65536);
    send_measurement(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_measurement(32'sh80000000, 32'sh80000000);
    send_measurement(32'sh7FFFFFFF, 32'sh80000000);
    send_measurement(32'sh80000000, 32'sh7FFFFFFF);
    send_measurement(-32'sd1, 32'sd1);
    send_measurement(32'sd655360, -32'sd65536);
    drain();
  endtask

  task automatic test_extreme_settings;
    write_all(31'd1, 31'd0, 31'd0, 31'd1);
    send_measurement(32'sd0, 32'sd0);
    send_measurement(32'sh7FFFFFFF, 32'sh80000000);
    send_measurement(32'sh80000000, 32'sh7FFFFFFF);
    send_measurement(32'sd1, -32'sd1);
    drain();
    write_all(31'd65536, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_measurement(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_measurement(32'sh80000000, 32'sh80000000);
    send_measurement(32'sd0, 32'sd0);
    send_measurement(32'sd12345678, -32'sd7654321);
    drain();
    write_all(31'h7FFFFFFF, 31'd65536, 31'd655360, 31'd1);
    send_measurement(32'sd65536, 32'sd65536);
    send_measurement(-32'sd65536, 32'sd0);
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    logic [CFG_WIDTH-1:0] dt;
    dt = ($urandom_range(3) == 0) ? CFG_WIDTH'($urandom_range(1, 65536))
                                  : CFG_WIDTH'($urandom_range(1, 6553));
    write_all(dt, CFG_WIDTH'($urandom), CFG_WIDTH'($urandom),
              CFG_WIDTH'($urandom_range(1, 32'h7FFFFFFF)));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_measurement(random_value(), random_value());
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (6) send_measurement(random_value(), random_value());
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= 4000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    estimate_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          e = pending_estimates.pop_front();
          if (position_estimate != e.pos[31:0])
            report_mismatch("position_estimate", position_estimate, e.pos);
          if (velocity_estimate != e.vel[31:0])
            report_mismatch("velocity_estimate", velocity_estimate, e.vel);
          if (saturated != e.sat)
            report_mismatch("saturated", saturated, e.sat);
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    measured_position = '0;
    control_input = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    dt_q = RST_TIME_STEP;
    qpos_q = RST_PROC_POS;
    qvel_q = RST_PROC_VEL;
    rmeas_q = RST_MEAS;
    x_pos = 0;
    x_vel = 0;
    foreach (cov[i]) cov[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_settings();
    test_extreme_settings();
    test_random_phase(0, 0, 260);
    test_random_phase(55, 0, 260);
    test_random_phase(0, 55, 260);
    test_random_phase(19, 19, 240);
    test_backpressure();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
